@@ hw/rtl/imu_sfd_pkg.sv @@
// ----------------------------------------------------------------------------
// imu_sfd_pkg
// Shared types and constants for the inertial sensor serial frame decoder.
// ----------------------------------------------------------------------------
package imu_sfd_pkg;

	// Configuration register indexes
	localparam int unsigned CFG_INDEX_W = 4;
	localparam logic [CFG_INDEX_W-1:0] CFG_HEADER      = 4'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_ACCEL_GAIN  = 4'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_RATE_GAIN   = 4'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_ANGLE_GAIN  = 4'd3;

	// Register reset values
	localparam logic [7:0]  HEADER_RESET     = 8'h55;
	localparam logic [11:0] ACCEL_GAIN_RESET = 12'd16;
	localparam logic [11:0] RATE_GAIN_RESET  = 12'd2000;
	localparam logic [11:0] ANGLE_GAIN_RESET = 12'd180;

	// Kind byte codes and the result kind codes they map to
	localparam logic [7:0] KIND_BYTE_ACCEL = 8'h51;
	localparam logic [7:0] KIND_BYTE_RATE  = 8'h52;
	localparam logic [7:0] KIND_BYTE_ANGLE = 8'h53;
	localparam logic [1:0] KIND_ACCEL = 2'd0;
	localparam logic [1:0] KIND_RATE  = 2'd1;
	localparam logic [1:0] KIND_ANGLE = 2'd2;

	// Frame layout: position 0 waits for header, 1..9 stored, 10 is checksum
	localparam logic [3:0] POS_IDLE = 4'd0;
	localparam logic [3:0] POS_LAST = 4'd10;
	localparam int unsigned STORE_DEPTH = 9;

	// Temperature: raw*256/340 = raw*64/85, done as |raw| * ceil(2^29/85) >> 23
	localparam logic [22:0]        TEMP_RECIP     = 23'd6316129;
	localparam int unsigned        TEMP_SHIFT     = 23;
	localparam logic signed [16:0] TEMP_OFFSET_Q8 = 17'sd9280;

	typedef struct packed {
		logic [7:0]  header;
		logic [11:0] accel_gain;
		logic [11:0] rate_gain;
		logic [11:0] angle_gain;
	} cfg_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [11:0]        gain;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
		logic signed [15:0] t;
	} frame_t;

endpackage

@@ hw/rtl/imu_sfd_regs.sv @@
// ----------------------------------------------------------------------------
// imu_sfd_regs
// Configuration registers: header byte and the three per-kind gains.
// ----------------------------------------------------------------------------
module imu_sfd_regs import imu_sfd_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [11:0]            cfg_data,
	output cfg_t                   cfg
);

	cfg_t cfg_q;

	// Writes are always taken; unknown indexes are dropped
	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header     <= HEADER_RESET;
			cfg_q.accel_gain <= ACCEL_GAIN_RESET;
			cfg_q.rate_gain  <= RATE_GAIN_RESET;
			cfg_q.angle_gain <= ANGLE_GAIN_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_HEADER:     cfg_q.header     <= cfg_data[7:0];
				CFG_ACCEL_GAIN: cfg_q.accel_gain <= cfg_data;
				CFG_RATE_GAIN:  cfg_q.rate_gain  <= cfg_data;
				CFG_ANGLE_GAIN: cfg_q.angle_gain <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

@@ hw/rtl/imu_sfd_collector.sv @@
// ----------------------------------------------------------------------------
// imu_sfd_collector
// Header hunt, byte counting and frame storage; hands a whole frame onward.
// ----------------------------------------------------------------------------
module imu_sfd_collector import imu_sfd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	input  cfg_t       cfg,
	input  logic       frame_take,
	output logic       frame_valid_s1,
	output frame_t     frame_s1
);

	logic [3:0] pos_q;
	logic [7:0] store_q [STORE_DEPTH];
	logic       accept;
	logic       at_last;
	logic       known;
	frame_t     frame_d;

	// Only the checksum byte needs room in the frame stage
	assign at_last  = (pos_q == POS_LAST);
	assign in_stall = at_last && frame_valid_s1 && !frame_take;
	assign accept   = in_valid && !in_stall;

	// Decode the kind byte and assemble the little-endian words
	always_comb begin
		known        = 1'b1;
		frame_d.kind = KIND_ACCEL;
		frame_d.gain = cfg.accel_gain;
		case (store_q[0])
			KIND_BYTE_ACCEL: begin
				frame_d.kind = KIND_ACCEL;
				frame_d.gain = cfg.accel_gain;
			end
			KIND_BYTE_RATE: begin
				frame_d.kind = KIND_RATE;
				frame_d.gain = cfg.rate_gain;
			end
			KIND_BYTE_ANGLE: begin
				frame_d.kind = KIND_ANGLE;
				frame_d.gain = cfg.angle_gain;
			end
			default: known = 1'b0;
		endcase
		frame_d.x = {store_q[2], store_q[1]};
		frame_d.y = {store_q[4], store_q[3]};
		frame_d.z = {store_q[6], store_q[5]};
		frame_d.t = {store_q[8], store_q[7]};
	end

	// Byte position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_IDLE;
		end else if (accept) begin
			if (pos_q == POS_IDLE) begin
				if (rx_byte == cfg.header)
					pos_q <= 4'd1;
			end else if (at_last) begin
				pos_q <= POS_IDLE;
			end else begin
				pos_q <= pos_q + 4'd1;
			end
		end
	end

	// Frame bytes 1..9; the checksum is not kept
	always_ff @(posedge clk) begin
		if (accept && pos_q != POS_IDLE && !at_last)
			store_q[4'(pos_q - 4'd1)] <= rx_byte;
	end

	// Frame stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_valid_s1 <= 1'b0;
		end else if (accept && at_last && known) begin
			frame_valid_s1 <= 1'b1;
		end else if (frame_take) begin
			frame_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && at_last && known)
			frame_s1 <= frame_d;
	end

endmodule

@@ hw/rtl/imu_sfd_scaler.sv @@
// ----------------------------------------------------------------------------
// imu_sfd_scaler
// Gain multiply of the three axes, temperature scaling, result register.
// ----------------------------------------------------------------------------
module imu_sfd_scaler import imu_sfd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               frame_valid_s1,
	input  frame_t             frame_s1,
	output logic               frame_take,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         frame_kind,
	output logic signed [27:0] x_value,
	output logic signed [27:0] y_value,
	output logic signed [27:0] z_value,
	output logic signed [16:0] temperature_q8
);

	logic               out_valid_q;
	logic               out_free;
	logic signed [12:0] gain_s;
	logic signed [28:0] x_full;
	logic signed [28:0] y_full;
	logic signed [28:0] z_full;
	logic [15:0]        t_mag;
	logic [38:0]        t_prod;
	logic [15:0]        t_quot;
	logic signed [16:0] t_div;
	logic signed [16:0] t_value;

	assign out_free   = !out_valid_q || !out_stall;
	assign frame_take = out_free;
	assign out_valid  = out_valid_q;

	// Axis words times gain
	assign gain_s = $signed({1'b0, frame_s1.gain});
	assign x_full = frame_s1.x * gain_s;
	assign y_full = frame_s1.y * gain_s;
	assign z_full = frame_s1.z * gain_s;

	// Temperature: divide by 85 via reciprocal on the magnitude, truncate to zero
	assign t_mag   = frame_s1.t[15] ? 16'(-frame_s1.t) : 16'(frame_s1.t);
	assign t_prod  = 39'(t_mag) * 39'(TEMP_RECIP);
	assign t_quot  = t_prod[TEMP_SHIFT +: 16];
	assign t_div   = frame_s1.t[15] ? -$signed({1'b0, t_quot}) : $signed({1'b0, t_quot});
	assign t_value = t_div + TEMP_OFFSET_Q8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= frame_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && frame_valid_s1) begin
			frame_kind     <= frame_s1.kind;
			x_value        <= x_full[27:0];
			y_value        <= y_full[27:0];
			z_value        <= z_full[27:0];
			temperature_q8 <= t_value;
		end
	end

endmodule

@@ hw/rtl/imu_serial_frame_decoder.sv @@
// ----------------------------------------------------------------------------
// imu_serial_frame_decoder
// Decodes 11-byte inertial sensor frames into scaled axis values.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall carrying rx_byte, one serial byte per
// item. Bytes are dropped until one equals the header register; that byte
// and the next ten form a frame. Byte 1 selects acceleration, angular rate
// or angle; other kind codes drop the frame with no result.
// Output channel: out_valid / out_stall with frame_kind, x/y/z values (raw
// word times the gain of that kind, 15 fractional bits) and temperature_q8.
// Config channel: cfg_valid / cfg_ready, cfg_index 0..3 selects header,
// accel, rate or angle gain; cfg_ready is always high. Write while idle.
// Throughput: one byte per cycle while in_stall is low. A result passes
// from the edge that takes the checksum byte into the frame register,
// then into the result register, with the gain multiply between them.
// Stall: a valid result holds while out_stall is high; one more frame
// waits in the frame register, and only a checksum byte that would need
// that full register is stalled. All other bytes keep flowing.
// Reset: registers take their defaults, the decoder waits for a header and
// no result is pending.
// ----------------------------------------------------------------------------
module imu_serial_frame_decoder import imu_sfd_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [7:0]             rx_byte,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [1:0]             frame_kind,
	output logic signed [27:0]     x_value,
	output logic signed [27:0]     y_value,
	output logic signed [27:0]     z_value,
	output logic signed [16:0]     temperature_q8,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [11:0]            cfg_data
);

	cfg_t   cfg;
	logic   frame_take;
	logic   frame_valid_s1;
	frame_t frame_s1;

	imu_sfd_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	imu_sfd_collector u_collector (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.rx_byte        (rx_byte),
		.cfg            (cfg),
		.frame_take     (frame_take),
		.frame_valid_s1 (frame_valid_s1),
		.frame_s1       (frame_s1)
	);

	imu_sfd_scaler u_scaler (
		.clk            (clk),
		.arst_n         (arst_n),
		.frame_valid_s1 (frame_valid_s1),
		.frame_s1       (frame_s1),
		.frame_take     (frame_take),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.frame_kind     (frame_kind),
		.x_value        (x_value),
		.y_value        (y_value),
		.z_value        (z_value),
		.temperature_q8 (temperature_q8)
	);

endmodule
